FILE: hw/rtl/urr_pkg.sv
package urr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int CORDIC_STEPS  = 30;
    localparam int SQRT_STEPS    = 31;
    localparam int TW            = 34;
    localparam int ZW            = 34;
    localparam int RW            = 64;
    localparam int QW            = 31;
    localparam int PIPE_DEPTH    = SQRT_STEPS + 2;

    localparam logic signed [TW-1:0] CORDIC_X0 = TW'(64'sd652032874);

    typedef logic [IN_W-1:0]          frac_t;
    typedef logic signed [OUT_W-1:0]  comp_t;
    typedef logic signed [TW-1:0]     trig_t;
    typedef logic signed [ZW-1:0]     ang_t;

    typedef struct packed {
        logic [1:0] quad1;
        logic [1:0] quad2;
    } quad_t;

    function automatic logic [ZW-1:0] turn_atan(input int i);
        logic [ZW-1:0] r;
        case (i)
            0:  r = ZW'(536870912);
            1:  r = ZW'(316933406);
            2:  r = ZW'(167458907);
            3:  r = ZW'(85004756);
            4:  r = ZW'(42667331);
            5:  r = ZW'(21354465);
            6:  r = ZW'(10679838);
            7:  r = ZW'(5340245);
            8:  r = ZW'(2670163);
            9:  r = ZW'(1335087);
            10: r = ZW'(667544);
            11: r = ZW'(333772);
            12: r = ZW'(166886);
            13: r = ZW'(83443);
            14: r = ZW'(41722);
            15: r = ZW'(20861);
            16: r = ZW'(10430);
            17: r = ZW'(5215);
            18: r = ZW'(2608);
            19: r = ZW'(1304);
            20: r = ZW'(652);
            21: r = ZW'(326);
            22: r = ZW'(163);
            23: r = ZW'(81);
            24: r = ZW'(41);
            25: r = ZW'(20);
            26: r = ZW'(10);
            27: r = ZW'(5);
            28: r = ZW'(3);
            29: r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] to_q32(input frac_t raw);
        logic [63:0] v;
        v = {48'd0, raw};
        if (FRACTION_BITS < 32)
            v = v << (32 - FRACTION_BITS);
        else
            v = v >> (FRACTION_BITS - 32);
        return v[31:0];
    endfunction

endpackage

FILE: hw/rtl/urr_if.sv
interface urr_in_if;
    import urr_pkg::*;
    logic  valid;
    logic  ready;
    frac_t u_radial;
    frac_t u_angle_xy;
    frac_t u_angle_wz;
    modport source (output valid, output u_radial, output u_angle_xy, output u_angle_wz,
                    input ready);
    modport sink (input valid, input u_radial, input u_angle_xy, input u_angle_wz,
                  output ready);
endinterface

interface urr_out_if;
    import urr_pkg::*;
    logic  valid;
    logic  ready;
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                  output ready);
endinterface

FILE: hw/rtl/urr_sqrt_cell.sv
module urr_sqrt_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic [4:0]            idx,
    input  logic [urr_pkg::RW-1:0] n_in,
    input  logic [urr_pkg::RW-1:0] r_in,
    output logic [urr_pkg::RW-1:0] n_out,
    output logic [urr_pkg::RW-1:0] r_out
);
    import urr_pkg::*;

    logic [RW-1:0] bit_val;
    logic [RW-1:0] trial;
    logic [RW-1:0] n_next;
    logic [RW-1:0] r_next;
    logic [RW-1:0] n_reg;
    logic [RW-1:0] r_reg;

    // one restoring step; bit = 4^idx
    always_comb
    begin
        bit_val = RW'(1) << {idx, 1'b0};
        trial   = r_in + bit_val;
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + bit_val;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;
endmodule

FILE: hw/rtl/urr_cordic_cell.sv
module urr_cordic_cell (
    input  logic           clk,
    input  logic           en,
    input  logic [4:0]     idx,
    input  urr_pkg::trig_t x_in,
    input  urr_pkg::trig_t y_in,
    input  urr_pkg::ang_t  z_in,
    output urr_pkg::trig_t x_out,
    output urr_pkg::trig_t y_out,
    output urr_pkg::ang_t  z_out
);
    import urr_pkg::*;

    trig_t x_next, y_next, x_reg, y_reg;
    ang_t  z_next, z_reg;
    trig_t dx, dy;
    ang_t  at;

    always_comb
    begin
        dx = y_in >>> idx;
        dy = x_in >>> idx;
        at = ang_t'(turn_atan(int'(idx)));
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

FILE: hw/rtl/urr_mul_cell.sv
module urr_mul_cell (
    input  logic                   clk,
    input  logic                   en,
    input  logic [urr_pkg::QW-1:0] mag,
    input  urr_pkg::trig_t         trig,
    output urr_pkg::comp_t         comp
);
    import urr_pkg::*;

    logic signed [QW+TW:0] prod;
    logic signed [QW+TW:0] rnd;
    logic signed [QW+TW:0] shf;
    comp_t comp_next, comp_reg;

    // q.60 product, round half up to q1.15, saturate
    always_comb
    begin
        prod = $signed({1'b0, mag}) * trig;
        rnd  = prod + ((QW+TW+1)'(1) <<< 44);
        shf  = rnd >>> 45;
        if (shf > 32767)
            comp_next = comp_t'(32767);
        else if (shf < -32768)
            comp_next = comp_t'(-32768);
        else
            comp_next = shf[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            comp_reg <= comp_next;
    end

    assign comp = comp_reg;
endmodule

FILE: hw/rtl/uniform_random_rotation_core.sv
// channel   | dir | payload                              | handshake
// in_req    | in  | u_radial, u_angle_xy, u_angle_wz     | valid/ready
// out_req   | out | quat_w, quat_x, quat_y, quat_z       | valid/ready
//
// one request per cycle while out is not held; stages: 31 square-root cells, one align stage, one multiply
// the cordic rows run 30 cells beside the square-root chain, one multiply stage last
// whole chain advances together; it stalls only when the last stage is full and out is held
// asynchronous active-low reset clears the valid bits; payload registers are not reset
module uniform_random_rotation_core (
    input  logic clk,
    input  logic rst_n,
    urr_in_if.sink    in_req,
    urr_out_if.source out_req
);
    import urr_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    // chain moves when the output slot is free or being emptied
    assign adv          = !vld_reg[PIPE_DEPTH-1] || out_req.ready;
    assign in_req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_req.valid};
    end

    // front stage: rescale, square-root operands, quarter-turn reduction
    logic [31:0]   u0, u1, u2;
    logic [RW-1:0] na0, nb0;
    logic [32:0]   q4_1, q4_2;
    ang_t          z1_0, z2_0;
    quad_t         quad0;

    always_comb
    begin
        u0   = to_q32(in_req.u_radial);
        u1   = to_q32(in_req.u_angle_xy);
        u2   = to_q32(in_req.u_angle_wz);
        na0  = {4'd0, u0, 28'd0};
        nb0  = (RW'(64'h1_0000_0000) - RW'(u0)) << 28;
        q4_1 = ({1'b0, u1} + 33'h2000_0000) >> 30;
        q4_2 = ({1'b0, u2} + 33'h2000_0000) >> 30;
        z1_0 = ang_t'({2'b00, u1}) - ang_t'({q4_1[2:0], 30'd0});
        z2_0 = ang_t'({2'b00, u2}) - ang_t'({q4_2[2:0], 30'd0});
        quad0.quad1 = q4_1[1:0];
        quad0.quad2 = q4_2[1:0];
    end

    // square-root chains (a and b)
    logic [RW-1:0] na [SQRT_STEPS+1];
    logic [RW-1:0] ra [SQRT_STEPS+1];
    logic [RW-1:0] nb [SQRT_STEPS+1];
    logic [RW-1:0] rb [SQRT_STEPS+1];
    assign na[0] = na0;
    assign nb[0] = nb0;
    assign ra[0] = '0;
    assign rb[0] = '0;

    // cordic chains, padded with delay to match sqrt depth
    trig_t x1 [CORDIC_STEPS+1];
    trig_t y1 [CORDIC_STEPS+1];
    ang_t  z1 [CORDIC_STEPS+1];
    trig_t x2 [CORDIC_STEPS+1];
    trig_t y2 [CORDIC_STEPS+1];
    ang_t  z2 [CORDIC_STEPS+1];
    assign x1[0] = CORDIC_X0;
    assign y1[0] = '0;
    assign z1[0] = z1_0;
    assign x2[0] = CORDIC_X0;
    assign y2[0] = '0;
    assign z2[0] = z2_0;

    quad_t quad_reg [CORDIC_STEPS];

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            urr_sqrt_cell u_a (.clk(clk), .en(adv), .idx(5'(SQRT_STEPS - 1 - g)),
                .n_in(na[g]), .r_in(ra[g]), .n_out(na[g+1]), .r_out(ra[g+1]));
            urr_sqrt_cell u_b (.clk(clk), .en(adv), .idx(5'(SQRT_STEPS - 1 - g)),
                .n_in(nb[g]), .r_in(rb[g]), .n_out(nb[g+1]), .r_out(rb[g+1]));
        end
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            urr_cordic_cell u_c1 (.clk(clk), .en(adv), .idx(5'(g)),
                .x_in(x1[g]), .y_in(y1[g]), .z_in(z1[g]),
                .x_out(x1[g+1]), .y_out(y1[g+1]), .z_out(z1[g+1]));
            urr_cordic_cell u_c2 (.clk(clk), .en(adv), .idx(5'(g)),
                .x_in(x2[g]), .y_in(y2[g]), .z_in(z2[g]),
                .x_out(x2[g+1]), .y_out(y2[g+1]), .z_out(z2[g+1]));
        end
    endgenerate

    // quadrant tag rides along
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quad_reg[0] <= quad0;
            for (int i = 1; i < CORDIC_STEPS; i++)
                quad_reg[i] <= quad_reg[i-1];
        end
    end

    // quadrant correction and extra delay stage on cordic results so they meet the sqrt output
    trig_t c1_reg, s1_reg, c2_reg, s2_reg;
    trig_t c1_next, s1_next, c2_next, s2_next;
    quad_t qd;
    assign qd = quad_reg[CORDIC_STEPS-1];

    always_comb
    begin
        case (qd.quad1)
            2'd0:    begin c1_next = x1[CORDIC_STEPS];  s1_next = y1[CORDIC_STEPS];  end
            2'd1:    begin c1_next = -y1[CORDIC_STEPS]; s1_next = x1[CORDIC_STEPS];  end
            2'd2:    begin c1_next = -x1[CORDIC_STEPS]; s1_next = -y1[CORDIC_STEPS]; end
            default: begin c1_next = y1[CORDIC_STEPS];  s1_next = -x1[CORDIC_STEPS]; end
        endcase
        case (qd.quad2)
            2'd0:    begin c2_next = x2[CORDIC_STEPS];  s2_next = y2[CORDIC_STEPS];  end
            2'd1:    begin c2_next = -y2[CORDIC_STEPS]; s2_next = x2[CORDIC_STEPS];  end
            2'd2:    begin c2_next = -x2[CORDIC_STEPS]; s2_next = -y2[CORDIC_STEPS]; end
            default: begin c2_next = y2[CORDIC_STEPS];  s2_next = -x2[CORDIC_STEPS]; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= c1_next;
            s1_reg <= s1_next;
            c2_reg <= c2_next;
            s2_reg <= s2_next;
        end
    end

    // cordic reaches stage 31 via delay register; sqrt reaches stage 31 directly
    logic [QW-1:0] a_mag, b_mag;
    assign a_mag = ra[SQRT_STEPS][QW-1:0];
    assign b_mag = rb[SQRT_STEPS][QW-1:0];

    // the sqrt chain ends at stage 31, cordic delay also at 31: align and register
    logic [QW-1:0] a_reg, b_reg;
    trig_t c1_d, s1_d, c2_d, s2_d;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_mag;
            b_reg <= b_mag;
            c1_d  <= c1_reg;
            s1_d  <= s1_reg;
            c2_d  <= c2_reg;
            s2_d  <= s2_reg;
        end
    end

    urr_mul_cell u_w (.clk(clk), .en(adv), .mag(a_reg), .trig(c2_d), .comp(out_req.quat_w));
    urr_mul_cell u_x (.clk(clk), .en(adv), .mag(b_reg), .trig(s1_d), .comp(out_req.quat_x));
    urr_mul_cell u_y (.clk(clk), .en(adv), .mag(b_reg), .trig(c1_d), .comp(out_req.quat_y));
    urr_mul_cell u_z (.clk(clk), .en(adv), .mag(a_reg), .trig(s2_d), .comp(out_req.quat_z));

    assign out_req.valid = vld_reg[PIPE_DEPTH-1];

    // a stalled output request keeps its payload (checked on quat_w and quat_x)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_req.valid && !out_req.ready |=> $stable(out_req.quat_w) && $stable(out_req.quat_x))
        else $error("output payload moved under stall");

    // input is taken whenever the last stage is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_req.valid |-> in_req.ready)
        else $error("chain stalled with free output slot");

    // an accepted request sets the first valid bit of the chain
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_req.valid && in_req.ready |=> vld_reg[0])
        else $error("accepted request lost at entry");
endmodule
